// ===== design/plt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, constants and register indexes of the tone curve block
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int LEVEL_BITS         = 8;
  localparam int CFG_DATA_BITS      = 64;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int COUNT_BITS         = 5;
  localparam int POINT_BITS         = 2 * LEVEL_BITS;
  localparam int POINTS_PER_REG     = CFG_DATA_BITS / POINT_BITS;
  localparam int DEF_MAX_POINTS     = 16;
  localparam int PROD_BITS          = 2 * LEVEL_BITS;
  localparam int QUO_BITS           = LEVEL_BITS;
  localparam int QUO_IDX_BITS       = $clog2(QUO_BITS);
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = QUO_BITS / DIV_BITS_PER_STAGE;

  localparam logic [LEVEL_BITS-1:0]     LEVEL_MAX = 8'd255;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POINTS_BASE = 3'd1;

  localparam logic [COUNT_BITS-1:0]    COUNT_RESET   = 5'd2;
  localparam logic [CFG_DATA_BITS-1:0] POINTS0_RESET = 64'h0000_0000_FFFF_0000;

  typedef logic [LEVEL_BITS-1:0] level_t;

  typedef struct packed {
    level_t y;
    level_t x;
  } point_t;

  // segment search result
  typedef struct packed {
    logic   direct;
    level_t base;
    level_t px;
    level_t nx;
    level_t ny;
    level_t level;
    logic   last;
  } seg_t;

  typedef struct packed {
    logic valid;
    seg_t data;
  } seg_stage_t;

  // divider working set
  typedef struct packed {
    logic                 direct;
    logic                 neg;
    level_t               base;
    logic [PROD_BITS-1:0] rem;
    level_t               den;
    logic [QUO_BITS-1:0]  quo;
    logic                 last;
  } div_t;

  typedef struct packed {
    logic valid;
    div_t data;
  } div_stage_t;

endpackage

// ===== design/plt_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_channels
// valid/ready channels for levels in, levels out and register writes
// ----------------------------------------------------------------------------
interface plt_in_if;
  logic                           valid;
  logic                           ready;
  logic [plt_pkg::LEVEL_BITS-1:0] level_in;
  logic                           last_in;

  modport source (output valid, level_in, last_in, input ready);
  modport sink   (input valid, level_in, last_in, output ready);
endinterface

interface plt_out_if;
  logic                           valid;
  logic                           ready;
  logic [plt_pkg::LEVEL_BITS-1:0] level_out;
  logic                           last_out;

  modport source (output valid, level_out, last_out, input ready);
  modport sink   (input valid, level_out, last_out, output ready);
endinterface

interface plt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [plt_pkg::CFG_INDEX_BITS-1:0] index;
  logic [plt_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/plt_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_cfg_regs
// point count and control point registers, written over the config channel
// ----------------------------------------------------------------------------
module plt_cfg_regs #(
  parameter int MAX_POINTS = plt_pkg::DEF_MAX_POINTS,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  plt_cfg_if.sink          cfg_ch,
  output logic [CNT_W-1:0] count_eff,
  output plt_pkg::point_t  points [MAX_POINTS]
);
  import plt_pkg::*;

  localparam logic [COUNT_BITS-1:0] MAXP = COUNT_BITS'(MAX_POINTS);

  logic [COUNT_BITS-1:0] count_r;
  point_t                points_r [MAX_POINTS];
  logic                  wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      for (int k = 0; k < MAX_POINTS; k++) begin
        points_r[k] <= (k < POINTS_PER_REG) ?
                       POINTS0_RESET[POINT_BITS*(k % POINTS_PER_REG) +: POINT_BITS] : '0;
      end
    end else if (wr) begin
      if (cfg_ch.index == CFG_POINT_COUNT) begin
        count_r <= cfg_ch.data[COUNT_BITS-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (cfg_ch.index == CFG_POINTS_BASE + CFG_INDEX_BITS'(k / POINTS_PER_REG)) begin
          points_r[k] <= cfg_ch.data[POINT_BITS*(k % POINTS_PER_REG) +: POINT_BITS];
        end
      end
    end
  end

  // counts above the table size use the whole table
  assign count_eff = (count_r > MAXP) ? CNT_W'(MAX_POINTS) : CNT_W'(count_r);
  assign points    = points_r;

endmodule

// ===== design/plt_seg_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_seg_search
// first pipeline stage: parallel x compares, priority pick, segment fetch
// ----------------------------------------------------------------------------
module plt_seg_search #(
  parameter int MAX_POINTS = plt_pkg::DEF_MAX_POINTS,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  plt_pkg::level_t      level,
  input  logic                 last,
  input  logic [CNT_W-1:0]     count_eff,
  input  plt_pkg::point_t      points [MAX_POINTS],
  output plt_pkg::seg_stage_t  stage_r
);
  import plt_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [MAX_POINTS-1:0] hit;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      prev;
  logic [IDX_W-1:0]      last_idx;
  logic                  found;
  seg_t                  seg;
  seg_stage_t            stage_nxt;

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      hit[k] = (CNT_W'(k) < count_eff) && (points[k].x >= level);
    end
    idx = '0;
    for (int k = MAX_POINTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        idx = IDX_W'(k);
      end
    end
  end

  assign found    = |hit;
  assign prev     = idx - IDX_W'(1);
  assign last_idx = IDX_W'(count_eff - CNT_W'(1));

  always_comb begin
    seg        = '0;
    seg.level  = level;
    seg.last   = last;
    seg.direct = 1'b1;
    if (count_eff == '0) begin
      seg.base = '0;
    end else if (count_eff == CNT_W'(1)) begin
      seg.base = points[0].y;
    end else if (!found) begin
      seg.base = points[last_idx].y;
    end else if (idx == '0) begin
      seg.base = points[0].y;
    end else begin
      seg.direct = 1'b0;
      seg.base   = points[prev].y;
      seg.px     = points[prev].x;
      seg.nx     = points[idx].x;
      seg.ny     = points[idx].y;
    end
  end

  assign stage_nxt.valid = in_valid;
  assign stage_nxt.data  = seg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (adv) begin
      stage_r.data <= stage_nxt.data;
    end
  end

endmodule

// ===== design/plt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_div
// pipelined restoring divider, a fixed number of quotient bits per stage
// ----------------------------------------------------------------------------
module plt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  plt_pkg::div_stage_t div_in,
  output plt_pkg::div_stage_t div_out
);
  import plt_pkg::*;

  div_stage_t stage_r [DIV_STAGES];

  function automatic div_t div_step(div_t d, int unsigned top);
    div_t                 r;
    logic [PROD_BITS-1:0] trial;
    int unsigned          b;
    r = d;
    for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
      b     = top - j;
      trial = PROD_BITS'(r.den) << b;
      if (r.rem >= trial) begin
        r.rem                       = r.rem - trial;
        r.quo[b[QUO_IDX_BITS-1:0]]  = 1'b1;
      end
    end
    return r;
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_stage_t src;
    div_stage_t stage_nxt;

    if (s == 0) begin : g_first
      assign src = div_in;
    end else begin : g_next
      assign src = stage_r[s-1];
    end

    assign stage_nxt.valid = src.valid;
    assign stage_nxt.data  = div_step(src.data, QUO_BITS - 1 - s * DIV_BITS_PER_STAGE);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[s].valid <= 1'b0;
      end else if (adv) begin
        stage_r[s].valid <= stage_nxt.valid;
      end
      if (adv) begin
        stage_r[s].data <= stage_nxt.data;
      end
    end
  end

  assign div_out = stage_r[DIV_STAGES-1];

endmodule

// ===== design/piecewise_linear_tone_curve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_tone_curve
// maps input levels through a tone curve of up to MAX_POINTS control points
// ----------------------------------------------------------------------------
// One level is accepted per cycle unless the pipeline stalls, and each result
// passes through one stage of parallel x compares and segment fetch, one stage
// of slope multiply, four divider stages of two quotient bits each, and the
// output register. A result held at the output stalls the whole pipeline,
// so in_ch.ready follows out_ch.ready while the output register is full.
// Control points are written through cfg_ch, which is always ready, and
// should only be changed while no level is in flight.
module piecewise_linear_tone_curve #(
  parameter int MAX_POINTS = plt_pkg::DEF_MAX_POINTS
) (
  input  logic       clk,
  input  logic       rst_n,
  plt_in_if.sink     in_ch,
  plt_out_if.source  out_ch,
  plt_cfg_if.sink    cfg_ch
);
  import plt_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [CNT_W-1:0] count_eff;
  point_t           points [MAX_POINTS];
  logic             adv;
  seg_stage_t       seg_r;
  div_stage_t       mul_r;
  div_stage_t       mul_nxt;
  div_stage_t       div_out;

  level_t               dl;
  level_t               den;
  level_t               mag;
  logic                 neg;
  logic [PROD_BITS-1:0] prod;

  logic                  out_valid_r;
  level_t                out_level_r;
  level_t                out_level_nxt;
  logic                  out_last_r;
  logic [LEVEL_BITS+1:0] sum;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  plt_cfg_regs #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .count_eff (count_eff),
    .points    (points)
  );

  plt_seg_search #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .level     (in_ch.level_in),
    .last      (in_ch.last_in),
    .count_eff (count_eff),
    .points    (points),
    .stage_r   (seg_r)
  );

  // slope stage: |dy| * (level - px), sign kept aside
  assign dl   = seg_r.data.level - seg_r.data.px;
  assign den  = seg_r.data.nx - seg_r.data.px;
  assign neg  = seg_r.data.ny < seg_r.data.base;
  assign mag  = neg ? (seg_r.data.base - seg_r.data.ny) : (seg_r.data.ny - seg_r.data.base);
  assign prod = {{LEVEL_BITS{1'b0}}, mag} * {{LEVEL_BITS{1'b0}}, dl};

  always_comb begin
    mul_nxt.valid       = seg_r.valid;
    mul_nxt.data.direct = seg_r.data.direct;
    mul_nxt.data.neg    = neg;
    mul_nxt.data.base   = seg_r.data.base;
    mul_nxt.data.rem    = prod;
    mul_nxt.data.den    = den;
    mul_nxt.data.quo    = '0;
    mul_nxt.data.last   = seg_r.data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.valid <= 1'b0;
    end else if (adv) begin
      mul_r.valid <= mul_nxt.valid;
    end
    if (adv) begin
      mul_r.data <= mul_nxt.data;
    end
  end

  plt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .div_in  (mul_r),
    .div_out (div_out)
  );

  // quotient truncates toward zero: applied as a signed magnitude
  assign sum = div_out.data.neg ?
               ({2'b00, div_out.data.base} - {2'b00, div_out.data.quo}) :
               ({2'b00, div_out.data.base} + {2'b00, div_out.data.quo});

  always_comb begin
    if (div_out.data.direct) begin
      out_level_nxt = div_out.data.base;
    end else if (sum[LEVEL_BITS+1]) begin
      out_level_nxt = '0;
    end else if (sum[LEVEL_BITS]) begin
      out_level_nxt = LEVEL_MAX;
    end else begin
      out_level_nxt = sum[LEVEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r <= out_level_nxt;
      out_last_r  <= div_out.data.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.level_out = out_level_r;
  assign out_ch.last_out  = out_last_r;

endmodule
